FILE: rtl/trz_pkg.sv
// Shared types and constants for the triangle rasterizer with depth store.
package trz_pkg;

   // Command codes on the request channel.
   typedef enum logic [1:0] {
      FUNC_CLEAR = 2'd0,
      FUNC_DRAW  = 2'd1,
      FUNC_READ  = 2'd2,
      FUNC_NOP   = 2'd3
   } trz_func_type;

   // Kinds of work entries passed from the front end to the back end.
   typedef enum logic [1:0] {
      KIND_PIXEL = 2'd0,
      KIND_DONE  = 2'd1,
      KIND_CLEAR = 2'd2,
      KIND_READ  = 2'd3
   } trz_kind_type;

   localparam int KIND_W = 2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_BLANK  = 2'd2;

   // Reset values of the configuration registers.
   localparam logic [7:0] WIDTH_RESET  = 8'd100;
   localparam logic [5:0] HEIGHT_RESET = 6'd30;
   localparam logic [7:0] BLANK_RESET  = 8'd46;

   // Depth saturation limits and the pixel counter ceiling.
   localparam logic signed [31:0] DEPTH_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] DEPTH_MIN = 32'sh8000_0000;
   localparam logic [12:0]        CNT_MAX   = 13'h1fff;

   // Last step indexes of the sequential units.
   localparam logic [5:0] RECIP_LAST = 6'd36;
   localparam logic [4:0] BARY_LAST  = 5'd24;
   localparam logic [2:0] SETUP_LAST = 3'd7;

   // Front end sequencer states.
   typedef enum logic [3:0] {
      F_IDLE,
      F_CMD,
      F_RECIP,
      F_SETUP,
      F_INIT,
      F_WALK,
      F_DIV,
      F_MUL,
      F_ACC,
      F_PUSH,
      F_FIN
   } trz_front_state_type;

   // Back end sequencer states.
   typedef enum logic [2:0] {
      B_INIT,
      B_IDLE,
      B_PIXEL,
      B_READ,
      B_CLEAR
   } trz_back_state_type;

endpackage

FILE: rtl/trz_fifo.sv
// Small queue of work entries between the front end and the back end.
module trz_fifo #(
   parameter int DATA_W = 64,
   parameter int DEPTH  = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic [DATA_W-1:0] pop_data,
   output logic              empty
);
   localparam int PTR_W = $clog2(DEPTH);

   logic [DATA_W-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0]  wptr_ff, wptr_in;
   logic [PTR_W-1:0]  rptr_ff, rptr_in;
   logic [PTR_W:0]    cnt_ff, cnt_in;
   logic              do_push, do_pop;

   // Occupancy flags and the entry at the head.
   assign full     = (cnt_ff == (PTR_W+1)'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_data = slot_ff[rptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // Pointer and count updates.
   always_comb begin
      wptr_in = do_push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in = do_pop ? rptr_ff + 1'b1 : rptr_ff;
      cnt_in  = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/trz_front.sv
// Front end: takes commands, sets up triangles, walks pixels and computes depth.
module trz_front #(
   parameter int MAX_WIDTH  = 128,
   parameter int MAX_HEIGHT = 32,
   localparam int STORE   = MAX_WIDTH * MAX_HEIGHT,
   localparam int IDX_W   = $clog2(STORE),
   localparam int ENTRY_W = trz_pkg::KIND_W + 1 + 8 + 32 + IDX_W
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          func,
   input  logic signed [16:0]  vx [3],
   input  logic signed [16:0]  vy [3],
   input  logic signed [23:0]  vz [3],
   input  logic [7:0]          colour,
   input  logic [11:0]         read_index,
   input  logic [7:0]          width_in_use,
   input  logic [5:0]          height_in_use,
   output logic                push,
   output logic [ENTRY_W-1:0]  push_data,
   input  logic                full
);
   import trz_pkg::*;

   localparam int XW = $clog2(MAX_WIDTH);
   localparam int YW = $clog2(MAX_HEIGHT);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);

   typedef struct packed {
      trz_kind_type      kind;
      logic              flag;
      logic [7:0]        colour;
      logic [31:0]       depth;
      logic [IDX_W-1:0]  idx;
   } entry_type;

   trz_front_state_type state_ff, state_in;

   // Latched command.
   trz_func_type       func_ff, func_in;
   logic signed [16:0] vx_ff [3], vx_in [3];
   logic signed [16:0] vy_ff [3], vy_in [3];
   logic signed [23:0] vz_ff [3], vz_in [3];
   logic [7:0]         colour_ff, colour_in;
   logic [11:0]        ridx_ff, ridx_in;

   // Reciprocal divider.
   logic [23:0]        rrem_ff, rrem_in;
   logic [36:0]        rq_ff, rq_in;
   logic [5:0]         rstep_ff, rstep_in;
   logic [1:0]         rk_ff, rk_in;
   logic signed [31:0] r_ff [3], r_in [3];

   // Bounding box and setup products.
   logic signed [17:0] bx0_ff, bx0_in, bx1_ff, bx1_in;
   logic signed [17:0] by0_ff, by0_in, by1_ff, by1_in;
   logic [2:0]         s_ff, s_in;
   logic signed [41:0] prod_ff [8], prod_in [8];
   logic [43:0]        absa_ff, absa_in;
   logic               degen_ff, degen_in;

   // Pixel walk.
   logic [XW-1:0]      x_ff, x_in;
   logic [YW-1:0]      y_ff, y_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [IDX_W-1:0]   rowidx_ff, rowidx_in;
   logic signed [43:0] ecur_ff [3], ecur_in [3];
   logic signed [43:0] erow_ff [3], erow_in [3];

   // Barycentric dividers and depth accumulation.
   logic [43:0]        rem_ff [3], rem_in [3];
   logic [24:0]        q_ff [3], q_in [3];
   logic [4:0]         dstep_ff, dstep_in;
   logic [1:0]         mk_ff, mk_in;
   logic signed [57:0] prod2_ff, prod2_in;
   logic signed [35:0] acc_ff, acc_in;

   // Combinational helpers.
   logic [WW-1:0]      w_eff;
   logic [HW-1:0]      h_eff;
   logic signed [20:0] xd_c [3], yd_c [3];
   logic signed [43:0] stepx_c [3], stepy_c [3];
   logic signed [17:0] minx_c, maxx_c, miny_c, maxy_c, wlim_c, hlim_c;
   logic signed [20:0] px0_c, py0_c, ma_c, mb_c;
   logic signed [41:0] mprod_c;
   logic signed [43:0] area_c;
   logic [23:0]        dz_c;
   logic [24:0]        rt_c;
   logic               rge_c;
   logic [36:0]        rqn_c;
   logic signed [31:0] rfin_c;
   logic               inside_c, allpos_c, allneg_c;
   logic               last_x_c, last_y_c, advance_c;
   logic [43:0]        dt_c [3];
   logic               dge_c [3];
   logic signed [57:0] biased_c;
   logic signed [33:0] term_c;
   logic signed [31:0] depth_c;
   logic               store_range_c;
   entry_type          entry_c;

   // Effective screen size.
   always_comb begin
      w_eff = (32'(width_in_use) < 32'(MAX_WIDTH)) ? WW'(width_in_use) : WW'(MAX_WIDTH);
      h_eff = (32'(height_in_use) < 32'(MAX_HEIGHT)) ? HW'(height_in_use) : HW'(MAX_HEIGHT);
   end

   // Doubled vertex coordinates and per-edge steps.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         xd_c[k] = 21'(vx_ff[k]) <<< 1;
         yd_c[k] = 21'(vy_ff[k]) <<< 1;
      end
      stepx_c[0] = 44'(yd_c[2] - yd_c[1]) <<< 1;
      stepy_c[0] = -(44'(xd_c[2] - xd_c[1]) <<< 1);
      stepx_c[1] = 44'(yd_c[0] - yd_c[2]) <<< 1;
      stepy_c[1] = -(44'(xd_c[0] - xd_c[2]) <<< 1);
      stepx_c[2] = 44'(yd_c[1] - yd_c[0]) <<< 1;
      stepy_c[2] = -(44'(xd_c[1] - xd_c[0]) <<< 1);
   end

   // Bounding box clamped to the screen in use.
   always_comb begin
      minx_c = 18'(vx_ff[0]);
      maxx_c = 18'(vx_ff[0]);
      miny_c = 18'(vy_ff[0]);
      maxy_c = 18'(vy_ff[0]);
      for (int k = 1; k < 3; k++) begin
         if (18'(vx_ff[k]) < minx_c) minx_c = 18'(vx_ff[k]);
         if (18'(vx_ff[k]) > maxx_c) maxx_c = 18'(vx_ff[k]);
         if (18'(vy_ff[k]) < miny_c) miny_c = 18'(vy_ff[k]);
         if (18'(vy_ff[k]) > maxy_c) maxy_c = 18'(vy_ff[k]);
      end
      wlim_c = $signed({7'd0, 11'(w_eff)}) - 18'sd1;
      hlim_c = $signed({7'd0, 11'(h_eff)}) - 18'sd1;
   end

   // Shared setup multiplier.
   always_comb begin
      px0_c = (21'(bx0_ff) <<< 1) + 21'sd1;
      py0_c = (21'(by0_ff) <<< 1) + 21'sd1;
      case (s_ff)
         3'd0:    begin ma_c = xd_c[2] - xd_c[0]; mb_c = yd_c[1] - yd_c[0]; end
         3'd1:    begin ma_c = yd_c[2] - yd_c[0]; mb_c = xd_c[1] - xd_c[0]; end
         3'd2:    begin ma_c = px0_c - xd_c[1];   mb_c = yd_c[2] - yd_c[1]; end
         3'd3:    begin ma_c = py0_c - yd_c[1];   mb_c = xd_c[2] - xd_c[1]; end
         3'd4:    begin ma_c = px0_c - xd_c[2];   mb_c = yd_c[0] - yd_c[2]; end
         3'd5:    begin ma_c = py0_c - yd_c[2];   mb_c = xd_c[0] - xd_c[2]; end
         3'd6:    begin ma_c = px0_c - xd_c[0];   mb_c = yd_c[1] - yd_c[0]; end
         default: begin ma_c = py0_c - yd_c[0];   mb_c = xd_c[1] - xd_c[0]; end
      endcase
      mprod_c = ma_c * mb_c;
      area_c  = 44'(prod_ff[0]) - 44'(prod_ff[1]);
   end

   // One step of the reciprocal divider: 2^36 over |z|, one quotient bit a cycle.
   always_comb begin
      dz_c  = vz_ff[rk_ff][23] ? 24'(-vz_ff[rk_ff]) : 24'(vz_ff[rk_ff]);
      rt_c  = {rrem_ff, (rstep_ff == '0)};
      rge_c = (rt_c >= {1'b0, dz_c});
      rqn_c = {rq_ff[35:0], rge_c};
      if (vz_ff[rk_ff] == '0) begin
         rfin_c = DEPTH_MAX;
      end else if (!vz_ff[rk_ff][23]) begin
         rfin_c = (rqn_c > 37'h0_7fff_ffff) ? DEPTH_MAX : $signed(rqn_c[31:0]);
      end else begin
         rfin_c = (rqn_c > 37'h0_8000_0000) ? DEPTH_MIN : -$signed(rqn_c[31:0]);
      end
   end

   // Coverage test and walk position.
   always_comb begin
      allpos_c  = !ecur_ff[0][43] && !ecur_ff[1][43] && !ecur_ff[2][43];
      allneg_c  = (ecur_ff[0] <= 0) && (ecur_ff[1] <= 0) && (ecur_ff[2] <= 0);
      inside_c  = allpos_c || allneg_c;
      last_x_c  = (x_ff == bx1_ff[XW-1:0]);
      last_y_c  = (y_ff == by1_ff[YW-1:0]);
      advance_c = ((state_ff == F_WALK) && !inside_c) || ((state_ff == F_PUSH) && !full);
   end

   // Barycentric divider lanes: |e| * 2^24 / |area|, one bit a cycle.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         dt_c[k]  = (dstep_ff == '0) ? rem_ff[k] : (rem_ff[k] << 1);
         dge_c[k] = (dt_c[k] >= absa_ff);
      end
   end

   // Depth term, rounded toward zero, and saturated depth.
   always_comb begin
      biased_c = prod2_ff + (prod2_ff[57] ? 58'sd16777215 : 58'sd0);
      term_c   = 34'(biased_c >>> 24);
      if (acc_ff > 36'(DEPTH_MAX)) begin
         depth_c = DEPTH_MAX;
      end else if (acc_ff < 36'(DEPTH_MIN)) begin
         depth_c = DEPTH_MIN;
      end else begin
         depth_c = acc_ff[31:0];
      end
      store_range_c = ({20'd0, ridx_ff} < 32'(STORE));
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         F_IDLE: begin
            if (start) begin
               state_in = (trz_func_type'(func) == FUNC_DRAW) ? F_RECIP : F_CMD;
            end
         end
         F_CMD: begin
            if (!full) state_in = F_IDLE;
         end
         F_RECIP: begin
            if (rstep_ff == RECIP_LAST && rk_ff == 2'd2) state_in = F_SETUP;
         end
         F_SETUP: begin
            if (s_ff == SETUP_LAST) state_in = F_INIT;
         end
         F_INIT: begin
            if (area_c == '0 || bx0_ff > bx1_ff || by0_ff > by1_ff) begin
               state_in = F_FIN;
            end else begin
               state_in = F_WALK;
            end
         end
         F_WALK: begin
            if (inside_c) begin
               state_in = F_DIV;
            end else if (last_x_c && last_y_c) begin
               state_in = F_FIN;
            end
         end
         F_DIV: begin
            if (dstep_ff == BARY_LAST) state_in = F_MUL;
         end
         F_MUL: begin
            state_in = F_ACC;
         end
         F_ACC: begin
            state_in = (mk_ff == 2'd2) ? F_PUSH : F_MUL;
         end
         F_PUSH: begin
            if (!full) state_in = (last_x_c && last_y_c) ? F_FIN : F_WALK;
         end
         F_FIN: begin
            if (!full) state_in = F_IDLE;
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   // Outputs: busy flag and queue entry.
   always_comb begin
      busy          = (state_ff != F_IDLE);
      push          = 1'b0;
      entry_c       = '0;
      entry_c.kind  = KIND_PIXEL;
      case (state_ff)
         F_CMD: begin
            push = !full;
            case (func_ff)
               FUNC_CLEAR: entry_c.kind = KIND_CLEAR;
               FUNC_READ: begin
                  entry_c.kind = KIND_READ;
                  entry_c.flag = store_range_c;
                  entry_c.idx  = IDX_W'({20'd0, ridx_ff});
               end
               default: entry_c.kind = KIND_DONE;
            endcase
         end
         F_PUSH: begin
            push           = !full;
            entry_c.kind   = KIND_PIXEL;
            entry_c.colour = colour_ff;
            entry_c.depth  = depth_c;
            entry_c.idx    = idx_ff;
         end
         F_FIN: begin
            push         = !full;
            entry_c.kind = KIND_DONE;
            entry_c.flag = degen_ff;
         end
         default: begin
            push = 1'b0;
         end
      endcase
      push_data = entry_c;
   end

   // Datapath next values.
   always_comb begin
      func_in   = func_ff;
      colour_in = colour_ff;
      ridx_in   = ridx_ff;
      rrem_in   = rrem_ff;
      rq_in     = rq_ff;
      rstep_in  = rstep_ff;
      rk_in     = rk_ff;
      bx0_in    = bx0_ff;
      bx1_in    = bx1_ff;
      by0_in    = by0_ff;
      by1_in    = by1_ff;
      s_in      = s_ff;
      absa_in   = absa_ff;
      degen_in  = degen_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      idx_in    = idx_ff;
      rowidx_in = rowidx_ff;
      dstep_in  = dstep_ff;
      mk_in     = mk_ff;
      prod2_in  = prod2_ff;
      acc_in    = acc_ff;
      for (int k = 0; k < 3; k++) begin
         vx_in[k]   = vx_ff[k];
         vy_in[k]   = vy_ff[k];
         vz_in[k]   = vz_ff[k];
         r_in[k]    = r_ff[k];
         ecur_in[k] = ecur_ff[k];
         erow_in[k] = erow_ff[k];
         rem_in[k]  = rem_ff[k];
         q_in[k]    = q_ff[k];
      end
      for (int j = 0; j < 8; j++) begin
         prod_in[j] = prod_ff[j];
      end

      case (state_ff)
         F_IDLE: begin
            if (start) begin
               func_in   = trz_func_type'(func);
               colour_in = colour;
               ridx_in   = read_index;
               for (int k = 0; k < 3; k++) begin
                  vx_in[k] = vx[k];
                  vy_in[k] = vy[k];
                  vz_in[k] = vz[k];
               end
               rrem_in  = '0;
               rq_in    = '0;
               rstep_in = '0;
               rk_in    = '0;
               degen_in = 1'b0;
            end
         end
         F_RECIP: begin
            bx0_in  = minx_c[17] ? 18'sd0 : minx_c;
            bx1_in  = (maxx_c > wlim_c) ? wlim_c : maxx_c;
            by0_in  = miny_c[17] ? 18'sd0 : miny_c;
            by1_in  = (maxy_c > hlim_c) ? hlim_c : maxy_c;
            rrem_in = rge_c ? 24'(rt_c - {1'b0, dz_c}) : rt_c[23:0];
            rq_in   = rqn_c;
            s_in    = '0;
            if (rstep_ff == RECIP_LAST) begin
               r_in[rk_ff] = rfin_c;
               rk_in       = rk_ff + 1'b1;
               rstep_in    = '0;
               rrem_in     = '0;
               rq_in       = '0;
            end else begin
               rstep_in = rstep_ff + 1'b1;
            end
         end
         F_SETUP: begin
            prod_in[s_ff] = mprod_c;
            s_in          = s_ff + 1'b1;
         end
         F_INIT: begin
            absa_in    = area_c[43] ? 44'(-area_c) : 44'(area_c);
            degen_in   = (area_c == '0);
            ecur_in[0] = 44'(prod_ff[2]) - 44'(prod_ff[3]);
            ecur_in[1] = 44'(prod_ff[4]) - 44'(prod_ff[5]);
            ecur_in[2] = 44'(prod_ff[6]) - 44'(prod_ff[7]);
            for (int k = 0; k < 3; k++) begin
               erow_in[k] = ecur_in[k];
            end
            x_in      = bx0_ff[XW-1:0];
            y_in      = by0_ff[YW-1:0];
            rowidx_in = IDX_W'(by0_ff[YW-1:0]) * IDX_W'(w_eff);
            idx_in    = IDX_W'(by0_ff[YW-1:0]) * IDX_W'(w_eff) + IDX_W'(bx0_ff[XW-1:0]);
         end
         F_WALK: begin
            if (inside_c) begin
               dstep_in = '0;
               for (int k = 0; k < 3; k++) begin
                  rem_in[k] = ecur_ff[k][43] ? 44'(-ecur_ff[k]) : 44'(ecur_ff[k]);
                  q_in[k]   = '0;
               end
            end
         end
         F_DIV: begin
            for (int k = 0; k < 3; k++) begin
               rem_in[k] = dge_c[k] ? dt_c[k] - absa_ff : dt_c[k];
               q_in[k]   = {q_ff[k][23:0], dge_c[k]};
            end
            dstep_in = dstep_ff + 1'b1;
            mk_in    = '0;
            acc_in   = '0;
         end
         F_MUL: begin
            prod2_in = $signed({1'b0, q_ff[mk_ff]}) * r_ff[mk_ff];
         end
         F_ACC: begin
            acc_in = acc_ff + 36'(term_c);
            mk_in  = mk_ff + 1'b1;
         end
         default: begin
            mk_in = mk_ff;
         end
      endcase

      // Step to the next pixel of the box, row by row.
      if (advance_c && !(last_x_c && last_y_c)) begin
         if (last_x_c) begin
            x_in      = bx0_ff[XW-1:0];
            y_in      = y_ff + 1'b1;
            rowidx_in = rowidx_ff + IDX_W'(w_eff);
            idx_in    = rowidx_ff + IDX_W'(w_eff) + IDX_W'(bx0_ff[XW-1:0]);
            for (int k = 0; k < 3; k++) begin
               erow_in[k] = erow_ff[k] + stepy_c[k];
               ecur_in[k] = erow_ff[k] + stepy_c[k];
            end
         end else begin
            x_in   = x_ff + 1'b1;
            idx_in = idx_ff + 1'b1;
            for (int k = 0; k < 3; k++) begin
               ecur_in[k] = ecur_ff[k] + stepx_c[k];
            end
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      func_ff   <= func_in;
      colour_ff <= colour_in;
      ridx_ff   <= ridx_in;
      rrem_ff   <= rrem_in;
      rq_ff     <= rq_in;
      rstep_ff  <= rstep_in;
      rk_ff     <= rk_in;
      bx0_ff    <= bx0_in;
      bx1_ff    <= bx1_in;
      by0_ff    <= by0_in;
      by1_ff    <= by1_in;
      s_ff      <= s_in;
      absa_ff   <= absa_in;
      degen_ff  <= degen_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      idx_ff    <= idx_in;
      rowidx_ff <= rowidx_in;
      dstep_ff  <= dstep_in;
      mk_ff     <= mk_in;
      prod2_ff  <= prod2_in;
      acc_ff    <= acc_in;
      for (int k = 0; k < 3; k++) begin
         vx_ff[k]   <= vx_in[k];
         vy_ff[k]   <= vy_in[k];
         vz_ff[k]   <= vz_in[k];
         r_ff[k]    <= r_in[k];
         ecur_ff[k] <= ecur_in[k];
         erow_ff[k] <= erow_in[k];
         rem_ff[k]  <= rem_in[k];
         q_ff[k]    <= q_in[k];
      end
      for (int j = 0; j < 8; j++) begin
         prod_ff[j] <= prod_in[j];
      end
   end

endmodule

FILE: rtl/trz_back.sv
// Back end: owns the colour and depth stores and carries out queued work.
module trz_back #(
   parameter int MAX_WIDTH  = 128,
   parameter int MAX_HEIGHT = 32,
   localparam int STORE   = MAX_WIDTH * MAX_HEIGHT,
   localparam int IDX_W   = $clog2(STORE),
   localparam int ENTRY_W = trz_pkg::KIND_W + 1 + 8 + 32 + IDX_W
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [ENTRY_W-1:0]  pop_data,
   input  logic                empty,
   output logic                pop,
   input  logic [7:0]          blank_char,
   output logic                init_busy,
   output logic                rsp_strobe,
   output logic [7:0]          rsp_read_colour,
   output logic signed [31:0]  rsp_read_depth,
   output logic [12:0]         rsp_pixels_written,
   output logic                rsp_degenerate
);
   import trz_pkg::*;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STORE - 1);

   typedef struct packed {
      trz_kind_type      kind;
      logic              flag;
      logic [7:0]        colour;
      logic [31:0]       depth;
      logic [IDX_W-1:0]  idx;
   } entry_type;

   trz_back_state_type state_ff, state_in;
   logic [IDX_W-1:0]   addr_ff, addr_in;
   entry_type          cur_ff, cur_in;
   logic [12:0]        count_ff, count_in;
   logic               strobe_ff, strobe_in;
   logic [7:0]         rcol_ff, rcol_in;
   logic signed [31:0] rdep_ff, rdep_in;
   logic [12:0]        rcnt_ff, rcnt_in;
   logic               rdeg_ff, rdeg_in;

   // Store ports.
   logic [7:0]         colour_mem [STORE];
   logic signed [31:0] depth_mem [STORE];
   logic [7:0]         rd_colour_ff;
   logic signed [31:0] rd_depth_ff;
   logic               we_c;
   logic [IDX_W-1:0]   wa_c;
   logic [7:0]         wcol_c;
   logic signed [31:0] wdep_c;
   entry_type          head_c;

   assign head_c    = entry_type'(pop_data);
   assign init_busy = (state_ff == B_INIT);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_INIT: begin
            if (addr_ff == LAST_IDX) state_in = B_IDLE;
         end
         B_IDLE: begin
            if (!empty) begin
               case (head_c.kind)
                  KIND_PIXEL: state_in = B_PIXEL;
                  KIND_READ:  state_in = B_READ;
                  KIND_CLEAR: state_in = B_CLEAR;
                  default:    state_in = B_IDLE;
               endcase
            end
         end
         B_PIXEL: state_in = B_IDLE;
         B_READ:  state_in = B_IDLE;
         B_CLEAR: begin
            if (addr_ff == LAST_IDX) state_in = B_IDLE;
         end
         default: state_in = B_IDLE;
      endcase
   end

   // Store writes, counters and the result beat.
   always_comb begin
      pop       = 1'b0;
      we_c      = 1'b0;
      wa_c      = addr_ff;
      wcol_c    = blank_char;
      wdep_c    = '0;
      addr_in   = addr_ff;
      cur_in    = cur_ff;
      count_in  = count_ff;
      strobe_in = 1'b0;
      rcol_in   = '0;
      rdep_in   = '0;
      rcnt_in   = '0;
      rdeg_in   = 1'b0;
      case (state_ff)
         B_INIT: begin
            we_c    = 1'b1;
            wcol_c  = BLANK_RESET;
            addr_in = (addr_ff == LAST_IDX) ? '0 : addr_ff + 1'b1;
         end
         B_IDLE: begin
            if (!empty) begin
               pop    = 1'b1;
               cur_in = head_c;
               if (head_c.kind == KIND_DONE) begin
                  strobe_in = 1'b1;
                  rcnt_in   = count_ff;
                  rdeg_in   = head_c.flag;
                  count_in  = '0;
               end
            end
         end
         B_PIXEL: begin
            wa_c   = cur_ff.idx;
            wcol_c = cur_ff.colour;
            wdep_c = $signed(cur_ff.depth);
            if ($signed(cur_ff.depth) > rd_depth_ff) begin
               we_c     = 1'b1;
               count_in = (count_ff == CNT_MAX) ? count_ff : count_ff + 1'b1;
            end
         end
         B_READ: begin
            strobe_in = 1'b1;
            rcol_in   = cur_ff.flag ? rd_colour_ff : 8'd0;
            rdep_in   = cur_ff.flag ? rd_depth_ff : 32'sd0;
         end
         B_CLEAR: begin
            we_c = 1'b1;
            if (addr_ff == LAST_IDX) begin
               addr_in   = '0;
               strobe_in = 1'b1;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   // Colour and depth stores, one write and one registered read a cycle.
   always_ff @(posedge clock) begin
      if (we_c) begin
         colour_mem[wa_c] <= wcol_c;
         depth_mem[wa_c]  <= wdep_c;
      end
      rd_colour_ff <= colour_mem[head_c.idx];
      rd_depth_ff  <= depth_mem[head_c.idx];
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= B_INIT;
         addr_ff   <= '0;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         addr_ff   <= addr_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      rcol_ff <= rcol_in;
      rdep_ff <= rdep_in;
      rcnt_ff <= rcnt_in;
      rdeg_ff <= rdeg_in;
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_read_colour    = rcol_ff;
   assign rsp_read_depth     = rdep_ff;
   assign rsp_pixels_written = rcnt_ff;
   assign rsp_degenerate     = rdeg_ff;

endmodule

FILE: rtl/triangle_rasterizer_zbuffer.sv
// Top level of the triangle rasterizer with colour and depth stores.
//
// Commands enter on the req_ ports: start is taken at a clock edge where
// busy is low. Each command gives exactly one result beat on the rsp_ ports,
// marked by rsp_strobe for one cycle; the receiver cannot hold it off.
// The csr_ port writes width, height and blank colour with no wait.
//
// The front end sets up a draw with three 37-step reciprocal divisions
// and eight setup products, then walks the clamped bounding box: an
// uncovered pixel is skipped, a covered one passes through the three
// 25-step barycentric dividers and the shared depth multiplier. The back
// end takes each covered pixel from the queue and tests its depth.
// A read is answered from a registered store read; a clear sweeps the stores.
// A four-entry queue lets the front end take the next command while the
// back end still works on the last.
// After reset the back end sweeps both stores once with busy high;
// configuration writes are taken during it.
module triangle_rasterizer_zbuffer #(
   parameter int MAX_WIDTH  = 128,
   parameter int MAX_HEIGHT = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_func,
   input  logic signed [16:0] req_v0_x,
   input  logic signed [16:0] req_v0_y,
   input  logic signed [23:0] req_v0_z,
   input  logic signed [16:0] req_v1_x,
   input  logic signed [16:0] req_v1_y,
   input  logic signed [23:0] req_v1_z,
   input  logic signed [16:0] req_v2_x,
   input  logic signed [16:0] req_v2_y,
   input  logic signed [23:0] req_v2_z,
   input  logic [7:0]         req_colour,
   input  logic [11:0]        req_read_index,
   output logic               rsp_strobe,
   output logic [7:0]         rsp_read_colour,
   output logic signed [31:0] rsp_read_depth,
   output logic [12:0]        rsp_pixels_written,
   output logic               rsp_degenerate,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [7:0]         csr_wdata
);
   import trz_pkg::*;

   localparam int STORE   = MAX_WIDTH * MAX_HEIGHT;
   localparam int IDX_W   = $clog2(STORE);
   localparam int ENTRY_W = KIND_W + 1 + 8 + 32 + IDX_W;

   logic [7:0]         width_ff, width_in;
   logic [5:0]         height_ff, height_in;
   logic [7:0]         blank_ff, blank_in;
   logic signed [16:0] vx_c [3];
   logic signed [16:0] vy_c [3];
   logic signed [23:0] vz_c [3];
   logic               front_busy, init_busy;
   logic               push, full, pop, empty;
   logic [ENTRY_W-1:0] push_data, pop_data;

   // Configuration register writes.
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      blank_in  = blank_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_WIDTH:  width_in  = csr_wdata;
            CSR_HEIGHT: height_in = csr_wdata[5:0];
            CSR_BLANK:  blank_in  = csr_wdata;
            default:    width_in  = width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         blank_ff  <= BLANK_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         blank_ff  <= blank_in;
      end
   end

   // Vertex fields gathered per coordinate.
   assign vx_c[0] = req_v0_x;
   assign vx_c[1] = req_v1_x;
   assign vx_c[2] = req_v2_x;
   assign vy_c[0] = req_v0_y;
   assign vy_c[1] = req_v1_y;
   assign vy_c[2] = req_v2_y;
   assign vz_c[0] = req_v0_z;
   assign vz_c[1] = req_v1_z;
   assign vz_c[2] = req_v2_z;

   assign busy = front_busy || init_busy;

   trz_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start && !init_busy),
      .busy          (front_busy),
      .func          (req_func),
      .vx            (vx_c),
      .vy            (vy_c),
      .vz            (vz_c),
      .colour        (req_colour),
      .read_index    (req_read_index),
      .width_in_use  (width_ff),
      .height_in_use (height_ff),
      .push          (push),
      .push_data     (push_data),
      .full          (full)
   );

   trz_fifo #(
      .DATA_W (ENTRY_W),
      .DEPTH  (4)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (empty)
   );

   trz_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .pop_data           (pop_data),
      .empty              (empty),
      .pop                (pop),
      .blank_char         (blank_ff),
      .init_busy          (init_busy),
      .rsp_strobe         (rsp_strobe),
      .rsp_read_colour    (rsp_read_colour),
      .rsp_read_depth     (rsp_read_depth),
      .rsp_pixels_written (rsp_pixels_written),
      .rsp_degenerate     (rsp_degenerate)
   );

endmodule
